// ===== rtl/core/ldq_pkg.sv =====
// ldq_pkg: shared types and constants for the light darkness qualifier
// no dependencies; imported by light_darkness_qualifier and its test bench
package ldq_pkg;

    // field widths
    localparam int LEVEL_W = 16;   // q4.12 register / ambient width
    localparam int DIFF_W  = 15;   // diffuse light width
    localparam int SMOOTH_W = 17;  // smoothed and committed level width
    localparam int TIMER_W = 17;   // hold timer width
    localparam int CFG_IDX_W = 2;

    // one second in q4.12
    localparam logic [TIMER_W-1:0] ONE_SECOND = 17'd4096;

    // configuration reset values
    localparam logic signed [LEVEL_W-1:0] INTERIOR_THRESHOLD_RST = 16'sd0;
    localparam logic signed [LEVEL_W-1:0] EXTERIOR_THRESHOLD_RST = 16'sd0;
    localparam logic [LEVEL_W-1:0]        CHANGE_DELTA_RST       = 16'd307;
    localparam logic [LEVEL_W-1:0]        HOLD_TIME_RST          = 16'd12288;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INTERIOR_THRESHOLD = 2'd0,
        REG_EXTERIOR_THRESHOLD = 2'd1,
        REG_CHANGE_DELTA       = 2'd2,
        REG_HOLD_TIME          = 2'd3
    } t_cfg_reg;

    // item operation codes
    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_SAMPLE = 1'b1
    } t_operation;

endpackage

// ===== rtl/core/light_darkness_qualifier.sv =====
// light_darkness_qualifier: smoothed light level to qualified darkness flag
// depends on ldq_pkg for widths, reset values, register and operation codes
//
// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+-----------------------------------
// item in  | input     | i_valid / o_stall        | i_operation, i_elapsed, i_ambient_level,
//          |           |                          | i_diffuse_level, i_interior
// result   | output    | o_valid / i_stall        | o_dark, o_darkness_changed
// config   | input     | i_cfg_valid / o_cfg_ready| i_cfg_index, i_cfg_data
//
// an item transfer loads the input register; once the result register has
// room the update logic writes the state and the result register, which
// then offers the result; one item per cycle sustained while i_stall is low
// (set by the single state update path)
// reset is synchronous on i_rst_n low and clears state, config and valids
// an output stall holds the result register; the input register keeps
// accepting until it is also full, then o_stall rises
// config is always ready; users write it only while the block is idle (not enforced)
module light_darkness_qualifier (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // item input
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_operation,
    input  logic [ldq_pkg::LEVEL_W-1:0]            i_elapsed,
    input  logic signed [ldq_pkg::LEVEL_W-1:0]     i_ambient_level,
    input  logic [ldq_pkg::DIFF_W-1:0]             i_diffuse_level,
    input  logic                                   i_interior,
    // result output
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic                                   o_dark,
    output logic                                   o_darkness_changed,
    // configuration
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [ldq_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ldq_pkg::LEVEL_W-1:0]            i_cfg_data
);
    import ldq_pkg::*;

    // configuration registers
    logic signed [LEVEL_W-1:0] r_interior_threshold;
    logic signed [LEVEL_W-1:0] r_exterior_threshold;
    logic [LEVEL_W-1:0]        r_change_delta;
    logic [LEVEL_W-1:0]        r_hold_time;

    // input register
    logic                      r_in_valid;
    logic                      r_in_operation;
    logic [LEVEL_W-1:0]        r_in_elapsed;
    logic signed [LEVEL_W-1:0] r_in_ambient;
    logic [DIFF_W-1:0]         r_in_diffuse;
    logic                      r_in_interior;

    // qualifier state
    logic signed [SMOOTH_W-1:0] r_smoothed_level, n_smoothed_level;
    logic signed [SMOOTH_W-1:0] r_committed_level, n_committed_level;
    logic                       r_primed, n_primed;
    logic                       r_pending_valid, n_pending_valid;
    logic                       r_pending_dark, n_pending_dark;
    logic                       r_dark_flag, n_dark_flag;
    logic [TIMER_W-1:0]         r_hold_timer, n_hold_timer;

    // result register
    logic r_out_valid;
    logic r_out_dark;
    logic r_out_changed;
    logic n_changed;

    // handshake
    logic in_xfer;
    logic out_xfer;
    logic advance;

    assign out_xfer    = r_out_valid && !i_stall;
    // the input register moves into the result register when it has room
    assign advance     = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !advance;
    assign in_xfer     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    assign o_valid            = r_out_valid;
    assign o_dark             = r_out_dark;
    assign o_darkness_changed = r_out_changed;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interior_threshold <= INTERIOR_THRESHOLD_RST;
            r_exterior_threshold <= EXTERIOR_THRESHOLD_RST;
            r_change_delta       <= CHANGE_DELTA_RST;
            r_hold_time          <= HOLD_TIME_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_INTERIOR_THRESHOLD: r_interior_threshold <= i_cfg_data;
                REG_EXTERIOR_THRESHOLD: r_exterior_threshold <= i_cfg_data;
                REG_CHANGE_DELTA:       r_change_delta       <= i_cfg_data;
                REG_HOLD_TIME:          r_hold_time          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_operation <= i_operation;
            r_in_elapsed   <= i_elapsed;
            r_in_ambient   <= i_ambient_level;
            r_in_diffuse   <= i_diffuse_level;
            r_in_interior  <= i_interior;
        end
    end

    // update datapath
    logic signed [SMOOTH_W-1:0] ambient_clamped;
    logic signed [SMOOTH_W-1:0] level;
    logic signed [SMOOTH_W:0]   step_diff;
    logic signed [SMOOTH_W:0]   smooth_sum;
    logic signed [SMOOTH_W-1:0] smooth_new;
    logic signed [SMOOTH_W:0]   drift;
    logic [SMOOTH_W:0]          drift_mag;
    logic signed [SMOOTH_W-1:0] threshold;
    logic                       level_dark;
    logic                       smooth_dark;
    logic                       trigger;
    logic                       pend_v1;
    logic                       pend_d1;
    logic [TIMER_W-1:0]         timer1;
    logic [TIMER_W-1:0]         timer_cap;
    logic [TIMER_W:0]           timer_sum;

    always_comb begin
        // interior clamps negative ambient at zero
        if (r_in_interior && r_in_ambient[LEVEL_W-1]) begin
            ambient_clamped = '0;
        end else begin
            ambient_clamped = SMOOTH_W'(r_in_ambient);
        end
        level = ambient_clamped + $signed({{(SMOOTH_W-DIFF_W){1'b0}}, r_in_diffuse});

        threshold = r_in_interior ? SMOOTH_W'(r_interior_threshold)
                                  : SMOOTH_W'(r_exterior_threshold);
        level_dark = level < threshold;

        // half step toward the level, floor rounding via arithmetic shift
        step_diff  = (SMOOTH_W+1)'(level) - (SMOOTH_W+1)'(r_smoothed_level);
        smooth_sum = (SMOOTH_W+1)'(r_smoothed_level) + (step_diff >>> 1);
        smooth_new = smooth_sum[SMOOTH_W-1:0];

        drift     = (SMOOTH_W+1)'(smooth_new) - (SMOOTH_W+1)'(r_committed_level);
        drift_mag = drift[SMOOTH_W] ? unsigned'(-drift) : unsigned'(drift);
        smooth_dark = smooth_new < threshold;

        trigger = (drift_mag > {{(SMOOTH_W+1-LEVEL_W){1'b0}}, r_change_delta})
               && ((r_pending_valid && (r_pending_dark != smooth_dark))
                   || (r_dark_flag != smooth_dark));
        pend_v1 = trigger ? 1'b1 : r_pending_valid;
        pend_d1 = trigger ? smooth_dark : r_pending_dark;
        // timer restarts only when no change was pending yet
        timer1  = (trigger && !r_pending_valid) ? '0 : r_hold_timer;

        // tick path: timer saturates at hold time plus one second
        timer_cap = {1'b0, r_hold_time} + ONE_SECOND;
        timer_sum = {1'b0, r_hold_timer} + {{(TIMER_W+1-LEVEL_W){1'b0}}, r_in_elapsed};

        n_smoothed_level  = r_smoothed_level;
        n_committed_level = r_committed_level;
        n_primed          = r_primed;
        n_pending_valid   = r_pending_valid;
        n_pending_dark    = r_pending_dark;
        n_dark_flag       = r_dark_flag;
        n_hold_timer      = r_hold_timer;
        n_changed         = 1'b0;

        case (t_operation'(r_in_operation))
            OP_TICK: begin
                if (timer_sum > {1'b0, timer_cap}) begin
                    n_hold_timer = timer_cap;
                end else begin
                    n_hold_timer = timer_sum[TIMER_W-1:0];
                end
            end
            OP_SAMPLE: begin
                if (!r_primed) begin
                    // first sample primes the state
                    n_smoothed_level  = level;
                    n_committed_level = level;
                    n_dark_flag       = level_dark;
                    n_pending_valid   = 1'b0;
                    n_pending_dark    = 1'b0;
                    n_primed          = 1'b1;
                end else begin
                    n_smoothed_level = smooth_new;
                    if (trigger) begin
                        n_committed_level = smooth_new;
                    end
                    n_pending_valid = pend_v1;
                    n_pending_dark  = pend_d1;
                    n_hold_timer    = timer1;
                    // dark applies at once, light waits out the hold time
                    if (pend_v1 && (pend_d1 || (timer1 > {1'b0, r_hold_time}))) begin
                        n_dark_flag     = pend_d1;
                        n_changed       = pend_d1 != r_dark_flag;
                        n_pending_valid = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smoothed_level  <= '0;
            r_committed_level <= '0;
            r_primed          <= 1'b0;
            r_pending_valid   <= 1'b0;
            r_pending_dark    <= 1'b0;
            r_dark_flag       <= 1'b0;
            r_hold_timer      <= '0;
        end else if (advance) begin
            r_smoothed_level  <= n_smoothed_level;
            r_committed_level <= n_committed_level;
            r_primed          <= n_primed;
            r_pending_valid   <= n_pending_valid;
            r_pending_dark    <= n_pending_dark;
            r_dark_flag       <= n_dark_flag;
            r_hold_timer      <= n_hold_timer;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (out_xfer) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_dark    <= n_dark_flag;
            r_out_changed <= n_changed;
        end
    end

    // a pending change to dark never survives its own item
    a_no_pending_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pending_valid && r_pending_dark))
        else $error("pending dark change left unapplied");

    // nothing is pending before the first sample
    a_pending_needs_prime: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending_valid |-> r_primed)
        else $error("pending change before priming");

    // a tick item never reports a change
    a_tick_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (r_in_operation == OP_TICK)) |=> (o_valid && !o_darkness_changed))
        else $error("tick item reported a darkness change");

    // a reported change really flips the flag
    a_change_flips: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && n_changed) |=> (r_dark_flag != $past(r_dark_flag)))
        else $error("darkness change reported without a flag flip");

endmodule

// ===== tb/light_darkness_qualifier_test.sv =====
// light_darkness_qualifier_test: self-checking bench for the darkness qualifier
// predicts each result from its own copy of smoothing, hold timer and config
// depends on ldq_pkg and the light_darkness_qualifier rtl only
module light_darkness_qualifier_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ldq_pkg::*;

    localparam int QUIET_LIMIT  = 1000; // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 4;    // extra wait after the last owed result
    localparam int LONG_HOLD    = 60;   // receiver hold-off that fills the block

    // one item as it crosses the input channel
    typedef struct packed {
        t_operation           op;
        logic [LEVEL_W-1:0]   elapsed;
        logic [LEVEL_W-1:0]   ambient;
        logic [DIFF_W-1:0]    diffuse;
        logic                 interior;
    } t_light_item;

    // one result as it leaves the output channel
    typedef struct packed {
        logic dark;
        logic changed;
    } t_flags;

    // dut inputs, all known from time zero
    logic                 i_clk              = 1'b0;
    logic                 i_rst_n            = 1'b0;
    logic                 i_valid            = 1'b0;
    logic                 o_stall;
    logic                 i_operation        = 1'b0;
    logic [LEVEL_W-1:0]   i_elapsed          = '0;
    logic [LEVEL_W-1:0]   i_ambient_level    = '0;
    logic [DIFF_W-1:0]    i_diffuse_level    = '0;
    logic                 i_interior         = 1'b0;
    logic                 o_valid;
    logic                 i_stall            = 1'b0;
    logic                 o_dark;
    logic                 o_darkness_changed;
    logic                 i_cfg_valid        = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index        = '0;
    logic [LEVEL_W-1:0]   i_cfg_data         = '0;

    light_darkness_qualifier u_top (.*);

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor state: config copy and qualifier state
    // ---------------------------------------------------------------
    logic signed [LEVEL_W-1:0]  cfg_int_thr = INTERIOR_THRESHOLD_RST;
    logic signed [LEVEL_W-1:0]  cfg_ext_thr = EXTERIOR_THRESHOLD_RST;
    logic [LEVEL_W-1:0]         cfg_delta   = CHANGE_DELTA_RST;
    logic [LEVEL_W-1:0]         cfg_hold    = HOLD_TIME_RST;

    logic signed [SMOOTH_W-1:0] smoothed    = '0;
    logic signed [SMOOTH_W-1:0] committed   = '0;
    logic [TIMER_W-1:0]         hold_timer  = '0;
    bit                         primed      = 1'b0;
    bit                         pend_valid  = 1'b0;
    bit                         pend_dark   = 1'b0;
    bit                         dark_flag   = 1'b0;

    t_flags expected_flags[$];   // results still owed by the block, oldest first
    int     mismatch_count = 0;

    // idling controls for sender and receiver
    bit tx_random    = 1'b0;
    bit rx_random    = 1'b0;
    int rx_hold_left = 0;
    int rx_gap_left  = 0;

    // advances the qualifier by one item and returns the flags it reports
    function automatic t_flags qualify_item(input t_light_item it);
        int     level, amb, s, diff, mag, cap, t, thr;
        bit     below;
        t_flags r;
        r.changed = 1'b0;
        if (it.op == OP_TICK) begin
            // timer saturates one second past the hold time
            cap = int'(cfg_hold) + int'(ONE_SECOND);
            t   = int'(hold_timer) + int'(it.elapsed);
            hold_timer = 17'((t > cap) ? cap : t);
        end else begin
            thr = it.interior ? int'(cfg_int_thr) : int'(cfg_ext_thr);
            amb = int'($signed(it.ambient));
            // indoors there is no sky, negative ambient counts as none
            if (it.interior && amb < 0)
                amb = 0;
            level = amb + int'(it.diffuse);
            if (!primed) begin
                // first sample seeds everything, no change reported
                smoothed   = 17'(level);
                committed  = 17'(level);
                dark_flag  = level < thr;
                pend_valid = 1'b0;
                pend_dark  = 1'b0;
                primed     = 1'b1;
            end else begin
                // half step toward the new level, floor on the shift
                s = int'(smoothed);
                s = s + ((level - s) >>> 1);
                smoothed = 17'(s);
                diff = s - int'(committed);
                mag  = (diff < 0) ? -diff : diff;
                if (mag > int'(cfg_delta)) begin
                    below = s < thr;
                    if ((pend_valid && pend_dark != below) || dark_flag != below) begin
                        // timer restarts only when nothing was pending yet
                        if (!pend_valid)
                            hold_timer = '0;
                        pend_valid = 1'b1;
                        pend_dark  = below;
                        committed  = smoothed;
                    end
                end
                // dark applies at once, light waits for the hold time
                if (pend_valid && (pend_dark || int'(hold_timer) > int'(cfg_hold))) begin
                    if (pend_dark != dark_flag) begin
                        dark_flag = pend_dark;
                        r.changed = 1'b1;
                    end
                    pend_valid = 1'b0;
                end
            end
        end
        r.dark = dark_flag;
        return r;
    endfunction

    // random item, mostly with levels close to the active threshold so that
    // the pending and hold logic gets exercised, sometimes fully random
    function automatic t_light_item random_item();
        t_light_item it;
        int          thr, span, lvl, dif, amb;
        it.op       = ($urandom_range(0, 99) < 35) ? OP_TICK : OP_SAMPLE;
        it.interior = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0)
            it.elapsed = 16'($urandom);
        else
            it.elapsed = 16'($urandom_range(0, int'(cfg_hold) / 4 + 64));
        if ($urandom_range(0, 7) == 0) begin
            it.ambient = 16'($urandom);
            it.diffuse = 15'($urandom);
        end else begin
            thr  = it.interior ? int'(cfg_int_thr) : int'(cfg_ext_thr);
            span = ($urandom_range(0, 1) == 0) ? 512 : 6000;
            lvl  = thr + int'($urandom_range(0, 2 * span)) - span;
            dif  = int'($urandom_range(0, 4095));
            amb  = lvl - dif;
            if (amb < -32768)
                amb = -32768;
            if (amb > 32767)
                amb = 32767;
            it.ambient = 16'(amb);
            it.diffuse = 15'(dif);
        end
        return it;
    endfunction

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offers one item, holds it until the transfer, then predicts its result
    task automatic send_item(input t_light_item it);
        // optional idle burst before the item, the only place send_item drops valid
        if (tx_random && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_operation     <= it.op;
        i_elapsed       <= it.elapsed;
        i_ambient_level <= it.ambient;
        i_diffuse_level <= it.diffuse;
        i_interior      <= it.interior;
        do @(posedge i_clk); while (o_stall);
        expected_flags.push_back(qualify_item(it));
    endtask

    task automatic send_tick(input logic [LEVEL_W-1:0] elapsed);
        t_light_item it;
        it         = '0;
        it.op      = OP_TICK;
        it.elapsed = elapsed;
        send_item(it);
    endtask

    task automatic send_sample(input logic [LEVEL_W-1:0] ambient,
                               input logic [DIFF_W-1:0] diffuse, input bit is_interior);
        t_light_item it;
        it          = '0;
        it.op       = OP_SAMPLE;
        it.ambient  = ambient;
        it.diffuse  = diffuse;
        it.interior = is_interior;
        send_item(it);
    endtask

    // stop offering and wait until every owed result has come out
    task automatic settle();
        i_valid <= 1'b0;
        while (expected_flags.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // one register write; valid stays up so writes can go back to back
    task automatic write_reg(input t_cfg_reg idx, input logic [LEVEL_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_INTERIOR_THRESHOLD: cfg_int_thr = val;
            REG_EXTERIOR_THRESHOLD: cfg_ext_thr = val;
            REG_CHANGE_DELTA:       cfg_delta   = val;
            REG_HOLD_TIME:          cfg_hold    = val;
            default: ;
        endcase
    endtask

    // writes all four registers, only called with the block idle
    task automatic load_settings(input logic [LEVEL_W-1:0] int_thr, ext_thr, delta, hold);
        write_reg(REG_INTERIOR_THRESHOLD, int_thr);
        write_reg(REG_EXTERIOR_THRESHOLD, ext_thr);
        write_reg(REG_CHANGE_DELTA, delta);
        write_reg(REG_HOLD_TIME, hold);
        i_cfg_valid <= 1'b0;
    endtask

    // one phase of random items under one register setting
    task automatic run_random(input logic [LEVEL_W-1:0] int_thr, ext_thr, delta, hold,
                              input int count, input bit idle);
        settle();
        load_settings(int_thr, ext_thr, delta, hold);
        tx_random = idle;
        rx_random = idle;
        repeat (count)
            send_item(random_item());
    endtask

    // ---------------------------------------------------------------
    // receiver side: random stall bursts, plus a long hold on request
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_stall <= 1'b1;
            rx_hold_left--;
        end else if (rx_random && rx_gap_left > 0) begin
            i_stall <= 1'b1;
            rx_gap_left--;
        end else begin
            i_stall     <= 1'b0;
            rx_gap_left = 0;
            if (rx_random && $urandom_range(0, 5) == 0)
                rx_gap_left = $urandom_range(1, 11);
        end
    end

    // compare every result transfer with the oldest prediction
    t_flags want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_flags.size() == 0) begin
                $error("result with none owed: dark %0b changed %0b",
                       o_dark, o_darkness_changed);
                mismatch_count++;
            end else begin
                want = expected_flags.pop_front();
                if (o_dark !== want.dark) begin
                    $error("dark: expected %0b, actual %0b", want.dark, o_dark);
                    mismatch_count++;
                end
                if (o_darkness_changed !== want.changed) begin
                    $error("darkness_changed: expected %0b, actual %0b",
                           want.changed, o_darkness_changed);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without any transfer on any channel
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // reset settings: tick before any sample, priming sample, then a change
    // to light that has to wait out the hold time
    task automatic test_priming_and_hold();
        send_tick(16'hFFFF);                 // saturates before priming
        send_sample(16'h8000, 15'h0000, 0);  // primes at the lowest level, dark
        send_sample(16'h7FFF, 15'h7FFF, 0);  // highest level, light goes pending
        send_tick(16'h0000);
        send_tick(16'hFFFF);                 // timer past the hold time
        send_sample(16'h7FFF, 15'h7FFF, 0);  // light applied
        send_sample(16'h8000, 15'h0000, 1);  // interior clamps ambient to zero
        send_sample(16'hFFFF, 15'h0001, 1);
    endtask

    // thresholds at their extremes, zero delta, longest hold
    task automatic test_threshold_extremes();
        settle();
        load_settings(16'h7FFF, 16'h8000, 16'h0000, 16'hEFFF);
        send_sample(16'hFFFF, 15'h0000, 1);  // interior, dark at once
        send_sample(16'h8000, 15'h0000, 0);  // exterior never below the minimum
        send_tick(16'hFFFF);                 // saturates at hold plus one second
        send_sample(16'h8000, 15'h0000, 0);
        send_tick(16'h7FFF);
        send_sample(16'h7FFF, 15'h0000, 1);
    endtask

    // largest delta and zero hold: large swings without re-evaluation
    task automatic test_delta_ceiling();
        settle();
        load_settings(16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        send_sample(16'h8000, 15'h0000, 0);
        send_sample(16'h7FFF, 15'h7FFF, 0);
        send_tick(16'h0001);
        send_sample(16'h5555, 15'h2AAA, 1);
    endtask

    // hold time lowered below a running timer: the larger timer is compared
    // until the next tick clamps it
    task automatic test_hold_lowered();
        settle();
        load_settings(16'h0000, 16'h0000, 16'h0000, 16'hEFFF);
        send_sample(16'h8000, 15'h0000, 0);
        send_sample(16'h8000, 15'h0000, 0);  // settles dark
        send_sample(16'h7FFF, 15'h7FFF, 0);  // light pending, timer restarts
        send_tick(16'd40000);
        send_sample(16'h7FFF, 15'h7FFF, 0);  // still short of the hold time
        settle();
        load_settings(16'h0000, 16'h0000, 16'h0000, 16'd100);
        send_sample(16'h7FFF, 15'h7FFF, 0);  // timer already past the new hold
        send_tick(16'd5);                    // clamp to the new bound
    endtask

    // random phases across settings, extremes first
    task automatic test_random_settings();
        run_random(INTERIOR_THRESHOLD_RST, EXTERIOR_THRESHOLD_RST,
                   CHANGE_DELTA_RST, HOLD_TIME_RST, 300, 1'b1);
        run_random(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 250, 1'b1);
        run_random(16'h8000, 16'h7FFF, 16'hFFFF, 16'hEFFF, 200, 1'b0);
        run_random(16'($urandom), 16'($urandom), 16'($urandom_range(0, 2047)),
                   16'($urandom_range(0, 61439)), 300, 1'b1);
        run_random(16'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom_range(0, 61439)), 300, 1'b1);
    endtask

    // receiver holds off long enough that the block fills and stalls its
    // input while items keep coming, then the sender waits for every result
    task automatic test_backpressure();
        settle();
        tx_random    = 1'b0;
        rx_random    = 1'b0;
        rx_hold_left = LONG_HOLD;
        repeat (24)
            send_item(random_item());
        settle();
    endtask

    // closing stretch at full rate with no idling on either side
    task automatic test_steady_stream();
        run_random(16'($urandom), 16'($urandom), 16'($urandom_range(0, 1023)),
                   16'($urandom_range(0, 16383)), 200, 1'b0);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_priming_and_hold();
        test_threshold_extremes();
        test_delta_ceiling();
        test_hold_lowered();
        test_random_settings();
        test_backpressure();
        test_steady_stream();
        settle();
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
